// ===== rtl/indexed_list_store_core_macros.svh =====
// ----------------------------------------------------------------------------
// indexed_list_store_core_macros.svh
// Assertion helpers for the indexed list store RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

// Plain clocked property, disabled while in reset.
`define ILS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication: ante |-> cons.
`define ILS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Clocked next-cycle implication: ante |=> cons.
`define ILS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  // request functions
  localparam logic [2:0] FN_READ      = 3'd0;
  localparam logic [2:0] FN_INS_FRONT = 3'd1;
  localparam logic [2:0] FN_INS_BACK  = 3'd2;
  localparam logic [2:0] FN_INS_AT    = 3'd3;
  localparam logic [2:0] FN_DELETE    = 3'd4;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;

  localparam int unsigned POS_W = 11;
  localparam int unsigned LEN_W = 11;

  typedef struct packed {
    logic [2:0]        func;
    logic [POS_W-1:0]  position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [LEN_W-1:0]   length;
  } resp_t;

endpackage

// ===== rtl/indexed_list_store_core.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of signed 32-bit values with read, insert and delete by index.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  in_     | in  | in_valid / in_ready   | ils_pkg::req_t  (func, position,
//          |     |                       |                  item_value)
//  out_    | out | out_valid / out_ready | ils_pkg::resp_t (read_value,
//          |     |                       |                  status, length)
//
//  A read passes through RD and RDW; an insert or delete moves M entries
//  (up to CAPACITY - 1), one memory move per cycle through the single
//  read/write port pair of the entry RAM. A rejected or undefined request
//  goes straight to DONE.
//  Reset clears the length and the control state; RAM contents stay as is.
//  in_ready is high only in IDLE. A finished result waits in the output
//  register, so the next item is taken while out_ready is low; a further
//  result then waits in DONE until the register frees.
// ----------------------------------------------------------------------------
`include "indexed_list_store_core_macros.svh"

module indexed_list_store_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ils_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ils_pkg::resp_t out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // compare width: wide enough for both a position and a count
  localparam int unsigned XW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r,   idx_nxt;    // next RAM address to read while moving
  logic [AW-1:0] wa_r,    wa_nxt;     // write address of the pending move
  logic          pend_r,  pend_nxt;   // a read is in flight, write it back
  logic [CW-1:0] rem_r,   rem_nxt;    // moves still to issue
  logic [AW-1:0] tgt_r,   tgt_nxt;    // target position
  logic          ins_r,   ins_nxt;    // 1 insert (move up), 0 delete (move down)
  logic [31:0]   val_r,   val_nxt;
  logic [1:0]    st_r,    st_nxt;
  logic [31:0]   rdv_r,   rdv_nxt;

  logic           out_valid_r;
  ils_pkg::resp_t out_data_r;
  logic           out_load;

  // entry RAM: one write and one read port, registered read data
  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  // request decode helpers
  logic [XW-1:0] pos_x, cnt_x, tgt_x;
  logic          full;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_x = XW'(in_data.position);
  assign cnt_x = XW'(count_r);
  assign full  = (count_r == CW'(CAPACITY));

  assign raddr    = (state_r == S_MOVE) ? idx_r : tgt_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    wa_nxt    = wa_r;
    pend_nxt  = pend_r;
    rem_nxt   = rem_r;
    tgt_nxt   = tgt_r;
    ins_nxt   = ins_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    rdv_nxt   = rdv_r;
    tgt_x     = '0;
    we        = 1'b0;
    waddr     = wa_r;
    wdata     = rd_q;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt  = in_data.item_value;
          st_nxt   = ils_pkg::ST_OK;
          rdv_nxt  = ils_pkg::NO_VALUE;
          pend_nxt = 1'b0;
          state_nxt = S_DONE;
          unique case (in_data.func)
            ils_pkg::FN_READ: begin
              tgt_nxt = AW'(pos_x);
              if (pos_x < cnt_x) begin
                state_nxt = S_RD;
              end else begin
                st_nxt = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::FN_INS_FRONT, ils_pkg::FN_INS_BACK, ils_pkg::FN_INS_AT: begin
              if (in_data.func == ils_pkg::FN_INS_FRONT) begin
                tgt_x = '0;
              end else if (in_data.func == ils_pkg::FN_INS_BACK) begin
                tgt_x = cnt_x;
              end else begin
                tgt_x = pos_x;
              end
              tgt_nxt = AW'(tgt_x);
              ins_nxt = 1'b1;
              idx_nxt = AW'(count_r - CW'(1));
              rem_nxt = CW'(cnt_x - tgt_x);
              // range check wins over the full check
              if (tgt_x > cnt_x) begin
                st_nxt = ils_pkg::ST_RANGE;
              end else if (full) begin
                st_nxt = ils_pkg::ST_FULL;
              end else begin
                state_nxt = S_MOVE;
              end
            end
            ils_pkg::FN_DELETE: begin
              tgt_nxt = AW'(pos_x);
              ins_nxt = 1'b0;
              idx_nxt = AW'(pos_x + XW'(1));
              rem_nxt = CW'(cnt_x - pos_x - XW'(1));
              if (pos_x < cnt_x) begin
                state_nxt = S_MOVE;
              end else begin
                st_nxt = ils_pkg::ST_RANGE;
              end
            end
            default: begin
              // undefined function: no operation, status ok
            end
          endcase
        end
      end

      S_RD: begin
        // read of tgt_r issued this cycle
        state_nxt = S_RDW;
      end

      S_RDW: begin
        rdv_nxt   = rd_q;
        state_nxt = S_DONE;
      end

      S_MOVE: begin
        // write back the entry read last cycle
        if (pend_r) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rd_q;
        end
        if (rem_r != '0) begin
          pend_nxt = 1'b1;
          rem_nxt  = rem_r - CW'(1);
          if (ins_r) begin
            wa_nxt  = idx_r + AW'(1);
            idx_nxt = idx_r - AW'(1);
          end else begin
            wa_nxt  = idx_r - AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            // pipeline drained: place the new value or drop the tail
            if (ins_r) begin
              we        = 1'b1;
              waddr     = tgt_r;
              wdata     = val_r;
              count_nxt = count_r + CW'(1);
            end else begin
              count_nxt = count_r - CW'(1);
            end
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    wa_r  <= wa_nxt;
    rem_r <= rem_nxt;
    tgt_r <= tgt_nxt;
    ins_r <= ins_nxt;
    val_r <= val_nxt;
    st_r  <= st_nxt;
    rdv_r <= rdv_nxt;
    if (out_load) begin
      out_data_r.read_value <= rdv_r;
      out_data_r.status     <= st_r;
      out_data_r.length     <= ils_pkg::LEN_W'(count_r);
    end
  end

  // length never passes capacity
  `ILS_ASSERT(a_cnt_cap, count_r <= CW'(CAPACITY), "entry count above capacity")
  // length moves only at the end of a move sequence
  `ILS_ASSERT_NXT(a_cnt_hold, state_r != S_MOVE, $stable(count_r), "count changed outside move")
  // every issued move read is written back next cycle
  `ILS_ASSERT_NXT(a_move_wb, (state_r == S_MOVE) && (rem_r != '0), pend_r, "move read not written back")
  // a full report carries a full length
  `ILS_ASSERT_IMP(a_full_len, out_valid_r && (out_data_r.status == ils_pkg::ST_FULL), out_data_r.length == ils_pkg::LEN_W'(CAPACITY), "full status with short length")

endmodule
